// ----- rtl/xcfr_pkg.sv -----
`timescale 1ns / 1ps

package xcfr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned HOLD_LEN = 5;  // bytes held before the closing check byte
  localparam int unsigned FILL_W   = 3;
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HOLD_LEN);

  localparam int unsigned HDR_LIMIT_W  = 8;
  localparam int unsigned HB_WORD_W    = 32;
  localparam int unsigned TIMEOUT_W    = 16;
  localparam int unsigned NOW_W        = 32;
  localparam int unsigned TIME_BITS_DEF = 32;

  localparam logic [HDR_LIMIT_W-1:0] HDR_LIMIT_RST = 8'd15;
  localparam logic [HB_WORD_W-1:0]   HB_WORD_RST   = 32'h9ABC_DEF0;
  localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RST   = 16'd1000;

  localparam logic [BYTE_W-1:0] HDR_HEARTBEAT = 8'd1;
  localparam logic [BYTE_W-1:0] HDR_SENSOR    = 8'd3;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HB_WORD      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd2;

  typedef enum logic [1:0] {
    KIND_OTHER     = 2'd0,
    KIND_HEARTBEAT = 2'd1,
    KIND_SENSOR    = 2'd2
  } kind_e;

  typedef logic [HOLD_LEN-1:0][BYTE_W-1:0] win_t;

  typedef struct packed {
    logic  good;        // full window passed header and checksum
    logic  drop;        // full window failed, shift out the oldest byte
    kind_e kind;
    logic  hb_hit;
    logic  sensor_hit;
  } chk_t;

endpackage

// ----- rtl/xcfr_check.sv -----
`timescale 1ns / 1ps

module xcfr_check import xcfr_pkg::*; (
  input  logic                   full_i,
  input  win_t                   win_i,
  input  logic [BYTE_W-1:0]      rx_byte_i,
  input  logic [HDR_LIMIT_W-1:0] header_limit_i,
  input  logic [HB_WORD_W-1:0]   heartbeat_word_i,
  output chk_t                   chk_o
);

  logic [BYTE_W-1:0]    xsum;
  logic [HB_WORD_W-1:0] word;
  logic                 pass;

  always_comb begin
    xsum = '0;
    for (int i = 0; i < HOLD_LEN; i++) begin
      xsum = xsum ^ win_i[i];
    end
  end

  assign word = {win_i[1], win_i[2], win_i[3], win_i[4]};
  assign pass = (win_i[0] <= header_limit_i) && (xsum == rx_byte_i);

  always_comb begin
    chk_o.good       = full_i && pass;
    chk_o.drop       = full_i && !pass;
    chk_o.hb_hit     = chk_o.good && (win_i[0] == HDR_HEARTBEAT) && (word == heartbeat_word_i);
    chk_o.sensor_hit = chk_o.good && (win_i[0] == HDR_SENSOR);
    if (chk_o.hb_hit) begin
      chk_o.kind = KIND_HEARTBEAT;
    end else if (chk_o.sensor_hit) begin
      chk_o.kind = KIND_SENSOR;
    end else begin
      chk_o.kind = KIND_OTHER;
    end
  end

endmodule

// ----- rtl/xor_checked_frame_receiver.sv -----
`timescale 1ns / 1ps

// Six-byte frame receiver for a radio byte stream: each accepted item is one
// byte plus a millisecond timestamp, and each produces exactly one result item
// in the output register. A frame is a header no larger than header_limit, four payload
// bytes and a check byte equal to the XOR of the first five; a failed full window
// drops its oldest byte to regain alignment. Header-1 frames matching the
// heartbeat word stamp the link time, header-3 frames latch the three distance
// readings, and link_connected reports a heartbeat younger than the timeout
// (times wrap modulo 2^TIME_BITS). Throughput is one item per clock: the header
// compare, five-byte XOR and timestamp subtract sit between the window registers
// and a single output register, and a new item is taken whenever that register
// is empty or being emptied. Configuration writes are always accepted; write
// them only while no result is pending.
module xor_checked_frame_receiver import xcfr_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [HB_WORD_W-1:0]  cfg_data_i,

  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [BYTE_W-1:0]     rx_byte_i,
  input  logic [NOW_W-1:0]      now_ms_i,

  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  frame_valid_o,
  output logic [1:0]            frame_kind_o,
  output logic [BYTE_W-1:0]     frame_header_o,
  output logic [BYTE_W-1:0]     payload_0_o,
  output logic [BYTE_W-1:0]     payload_1_o,
  output logic [BYTE_W-1:0]     payload_2_o,
  output logic [BYTE_W-1:0]     payload_3_o,
  output logic                  resync_drop_o,
  output logic [BYTE_W-1:0]     sensor_left_o,
  output logic [BYTE_W-1:0]     sensor_mid_o,
  output logic [BYTE_W-1:0]     sensor_right_o,
  output logic                  link_connected_o
);

  localparam int unsigned NOW_KEEP = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;

  // configuration
  logic [HDR_LIMIT_W-1:0] header_limit_q;
  logic [HB_WORD_W-1:0]   heartbeat_word_q;
  logic [TIMEOUT_W-1:0]   timeout_q;

  // receiver state
  win_t                   win_q;
  logic [FILL_W-1:0]      fill_q, fill_d;
  logic [TIME_BITS-1:0]   hb_time_q, hb_time_d;
  logic                   hb_seen_q, hb_seen_d;
  logic [BYTE_W-1:0]      left_q, left_d;
  logic [BYTE_W-1:0]      mid_q, mid_d;
  logic [BYTE_W-1:0]      right_q, right_d;

  // output register
  logic                   out_valid_q;
  logic                   frame_valid_q;
  kind_e                  kind_q;
  logic [BYTE_W-1:0]      header_q;
  logic [3:0][BYTE_W-1:0] payload_q;
  logic                   drop_q;
  logic                   conn_q;

  logic                   in_acc;
  logic                   full;
  chk_t                   chk;
  logic [TIME_BITS-1:0]   now_t;
  logic [TIME_BITS-1:0]   age;
  logic                   conn_d;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign full        = (fill_q == FILL_FULL);
  assign now_t       = TIME_BITS'(now_ms_i[NOW_KEEP-1:0]);

  xcfr_check u_check (
    .full_i           (full),
    .win_i            (win_q),
    .rx_byte_i        (rx_byte_i),
    .header_limit_i   (header_limit_q),
    .heartbeat_word_i (heartbeat_word_q),
    .chk_o            (chk)
  );

  always_comb begin
    fill_d    = fill_q;
    hb_time_d = hb_time_q;
    hb_seen_d = hb_seen_q;
    left_d    = left_q;
    mid_d     = mid_q;
    right_d   = right_q;
    if (chk.good) begin
      fill_d = '0;
    end else if (!full) begin
      fill_d = fill_q + FILL_W'(1);
    end
    if (chk.hb_hit) begin
      hb_time_d = now_t;
      hb_seen_d = 1'b1;
    end
    if (chk.sensor_hit) begin
      left_d  = win_q[1];
      mid_d   = win_q[2];
      right_d = win_q[3];
    end
  end

  assign age    = now_t - hb_time_d;
  assign conn_d = hb_seen_d && (age < TIME_BITS'(timeout_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_limit_q   <= HDR_LIMIT_RST;
      heartbeat_word_q <= HB_WORD_RST;
      timeout_q        <= TIMEOUT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HEADER_LIMIT: header_limit_q   <= cfg_data_i[HDR_LIMIT_W-1:0];
        CFG_HB_WORD:      heartbeat_word_q <= cfg_data_i;
        CFG_TIMEOUT:      timeout_q        <= cfg_data_i[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      hb_time_q <= '0;
      hb_seen_q <= 1'b0;
      left_q    <= '0;
      mid_q     <= '0;
      right_q   <= '0;
    end else if (in_acc) begin
      fill_q    <= fill_d;
      hb_time_q <= hb_time_d;
      hb_seen_q <= hb_seen_d;
      left_q    <= left_d;
      mid_q     <= mid_d;
      right_q   <= right_d;
    end
  end

  // window bytes are only read once all five are written, so no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (chk.drop) begin
        for (int i = 0; i < HOLD_LEN - 1; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[HOLD_LEN-1] <= rx_byte_i;
      end else if (!full) begin
        for (int i = 0; i < HOLD_LEN; i++) begin
          if (fill_q == FILL_W'(i)) begin
            win_q[i] <= rx_byte_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      frame_valid_q <= chk.good;
      kind_q        <= chk.kind;
      header_q      <= chk.good ? win_q[0] : '0;
      for (int i = 0; i < 4; i++) begin
        payload_q[i] <= chk.good ? win_q[i+1] : '0;
      end
      drop_q        <= chk.drop;
      conn_q        <= conn_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_valid_o    = frame_valid_q;
  assign frame_kind_o     = kind_q;
  assign frame_header_o   = header_q;
  assign payload_0_o      = payload_q[0];
  assign payload_1_o      = payload_q[1];
  assign payload_2_o      = payload_q[2];
  assign payload_3_o      = payload_q[3];
  assign resync_drop_o    = drop_q;
  assign sensor_left_o    = left_q;
  assign sensor_mid_o     = mid_q;
  assign sensor_right_o   = right_q;
  assign link_connected_o = conn_q;

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_FULL)
    else $error("window fill out of range");

  a_full_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && full) |=> (fill_q == '0 || fill_q == FILL_FULL))
    else $error("full window did not empty or resync");

  a_frame_or_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(frame_valid_q && drop_q))
    else $error("frame reported and dropped together");

  a_kind_needs_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q != KIND_OTHER) |-> frame_valid_q)
    else $error("frame kind without a frame");

  a_hb_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && chk.hb_hit) |=> (hb_seen_q && hb_time_q == $past(now_t)))
    else $error("heartbeat time not recorded");

endmodule
